// ===== hdl/bpsfp_pkg.sv =====
// Shared types and constants for the blood-pressure sensor frame parser.
// No dependencies; imported by bpsfp_ascii_dec and bp_sensor_frame_parser.
`default_nettype none

package bpsfp_pkg;

	// Default capture depth of an ASCII frame, STX included
	localparam int STORE_DEPTH_DEF = 256;

	// Highest frame-store index that any decode ever reads
	localparam int LAST_TAP = 24;
	localparam int TAP_W    = 5;

	// Framing bytes
	localparam logic [7:0] BYTE_STX  = 8'h02;
	localparam logic [7:0] BYTE_ETX  = 8'h03;
	localparam logic [7:0] BYTE_CR   = 8'h0D;
	localparam logic [7:0] BYTE_SYNC = 8'hFF;
	localparam logic [7:0] BYTE_ID   = 8'hCD;
	localparam logic [7:0] BYTE_READ = 8'h08;
	localparam logic [7:0] BYTE_ERR  = 8'h04;
	localparam logic [7:0] BYTE_SKIP = 8'h01;

	// Frame format register values
	localparam logic FMT_ASCII  = 1'b0;
	localparam logic FMT_BINARY = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_READING = 2'd0;
	localparam logic [1:0] KIND_FETCH   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Binary header progress codes
	localparam logic [1:0] HDR_IDLE = 2'd0;
	localparam logic [1:0] HDR_SYNC = 2'd1;
	localparam logic [1:0] HDR_ID   = 2'd2;
	localparam logic [1:0] HDR_READ = 2'd3;

	// Error code reported for any module code above the known range
	localparam logic [2:0] ECODE_MAX   = 3'd4;
	localparam logic [2:0] ECODE_OTHER = 3'd5;

	// ASCII payload pattern matches and decoded readings
	typedef struct packed {
		logic               fetch_pat;
		logic               read_pat;
		logic signed [10:0] sys;
		logic signed [10:0] dia;
		logic signed [10:0] rate;
	} ascii_dec_t;

endpackage

`default_nettype wire

// ===== hdl/bpsfp_ascii_dec.sv =====
// ASCII payload decode: pattern checks and three-digit decimal fields.
// Depends on bpsfp_pkg; reads the fixed frame-store taps of the top level.
`default_nettype none

module bpsfp_ascii_dec
	import bpsfp_pkg::*;
(
	input  wire logic [7:0] taps [1:LAST_TAP],
	output ascii_dec_t      dec
);

	// Parse up to three characters: blanks, optional sign, then digits
	function automatic logic signed [10:0] dec3(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2);
		logic [7:0] c [3];
		logic [1:0] phase;
		logic       neg;
		logic [9:0] v;
		logic       blank;
		logic       digit;
		c[0]  = c0;
		c[1]  = c1;
		c[2]  = c2;
		phase = 2'd0;
		neg   = 1'b0;
		v     = '0;
		for (int k = 0; k < 3; k++) begin
			blank = (c[k] == 8'h20) || (c[k] >= 8'h09 && c[k] <= 8'h0D);
			digit = (c[k] >= 8'h30) && (c[k] <= 8'h39);
			if (phase == 2'd0) begin
				if (blank) begin
					phase = 2'd0;
				end else if (c[k] == 8'h2B || c[k] == 8'h2D) begin
					neg   = (c[k] == 8'h2D);
					phase = 2'd1;
				end else if (digit) begin
					v     = {6'd0, c[k][3:0]};
					phase = 2'd1;
				end else begin
					phase = 2'd2;
				end
			end else if (phase == 2'd1) begin
				if (digit) begin
					v = 10'(v * 10'd10 + {6'd0, c[k][3:0]});
				end else begin
					phase = 2'd2;
				end
			end
		end
		return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

	// Match "999" and the "S1" ... "M03" reading layout
	always_comb begin
		dec.fetch_pat = (taps[1] == 8'h39) && (taps[2] == 8'h39) && (taps[3] == 8'h39);
		dec.read_pat  = (taps[1] == 8'h53) && (taps[2] == 8'h31) && (taps[11] == 8'h4D)
			&& (taps[12] == 8'h30) && (taps[13] == 8'h33);
		dec.sys  = dec3(taps[16], taps[17], taps[18]);
		dec.dia  = dec3(taps[19], taps[20], taps[21]);
		dec.rate = dec3(taps[22], taps[23], taps[24]);
	end

endmodule

`default_nettype wire

// ===== hdl/bp_sensor_frame_parser.sv =====
// Blood-pressure sensor frame parser, top level.
// Depends on bpsfp_pkg and bpsfp_ascii_dec.
`default_nettype none

// Channel   Handshake             Payload
// ------    ---------             -------
// input     in_valid / in_ready   rx_byte
// result    out_valid / out_ready result_kind, systolic, diastolic, heart_rate, error_kind
// config    cfg_wr_en             cfg_wr_data (frame_format)
//
// One byte is accepted per cycle, except while a byte with a result waits. A byte sits in
// the input register, where the frame state is advanced, and its result (if any) is loaded
// into the result register as the byte leaves it. Only a byte that produces a result waits
// for a full result register; bytes without a result pass straight through. Reset clears
// all parser state and the held readings, and sets the binary format.

module bp_sensor_frame_parser
	import bpsfp_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              result_kind,
	output logic signed [10:0]      systolic,
	output logic signed [10:0]      diastolic,
	output logic signed [10:0]      heart_rate,
	output logic [2:0]              error_kind
);

	localparam int PW = $clog2(STORE_DEPTH + 1);

	logic               fmt_q;
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic [PW-1:0]      pos_q,  pos_n;
	logic [1:0]         hdr_q,  hdr_n;
	logic               err_q,  err_n;
	logic [2:0]         cnt_q,  cnt_n;
	logic [7:0]         store_q [1:LAST_TAP];
	logic signed [10:0] sys_q,  sys_n;
	logic signed [10:0] dia_q,  dia_n;
	logic signed [10:0] rate_q, rate_n;
	logic               out_valid_q;
	logic [1:0]         kind_q;
	logic [2:0]         ekind_q;

	logic               emit;
	logic [1:0]         emit_kind;
	logic [2:0]         emit_ekind;
	logic               wr_en;
	logic [TAP_W-1:0]   wr_idx;
	logic [PW-1:0]      pos_a;
	logic [2:0]         cnt_inc;
	logic [7:0]         bb2, bb3, bb5, bb6;
	logic               fire_s1;
	ascii_dec_t         adec;

	bpsfp_ascii_dec u_dec (
		.taps (store_q),
		.dec  (adec)
	);

	// Store bytes as seen after this cycle's write, for the binary decode
	assign bb2 = (wr_en && wr_idx == TAP_W'(2)) ? byte_s1 : store_q[2];
	assign bb3 = (wr_en && wr_idx == TAP_W'(3)) ? byte_s1 : store_q[3];
	assign bb5 = (wr_en && wr_idx == TAP_W'(5)) ? byte_s1 : store_q[5];
	assign bb6 = (wr_en && wr_idx == TAP_W'(6)) ? byte_s1 : store_q[6];

	assign pos_a   = (byte_s1 == BYTE_CR) ? '0 : pos_q;
	assign cnt_inc = cnt_q + 3'd1;

	// Advance the frame state for the byte in the input register
	always_comb begin
		pos_n      = pos_q;
		hdr_n      = hdr_q;
		err_n      = err_q;
		cnt_n      = cnt_q;
		sys_n      = sys_q;
		dia_n      = dia_q;
		rate_n     = rate_q;
		emit       = 1'b0;
		emit_kind  = KIND_READING;
		emit_ekind = '0;
		wr_en      = 1'b0;
		wr_idx     = '0;
		if (fmt_q == FMT_ASCII) begin
			if (pos_a == '0 && byte_s1 == BYTE_STX) begin
				pos_n = PW'(1);
			end else if (pos_a != '0 && pos_a < PW'(STORE_DEPTH)) begin
				wr_en  = (pos_a <= PW'(LAST_TAP));
				wr_idx = pos_a[TAP_W-1:0];
				if (byte_s1 == BYTE_ETX) begin
					pos_n = '0;
					if (pos_a == PW'(4) && adec.fetch_pat) begin
						emit      = 1'b1;
						emit_kind = KIND_FETCH;
					end else if (pos_a >= PW'(LAST_TAP + 1) && adec.read_pat) begin
						emit   = 1'b1;
						sys_n  = adec.sys;
						dia_n  = adec.dia;
						rate_n = adec.rate;
					end
				end else begin
					pos_n = pos_a + PW'(1);
				end
			end else begin
				pos_n = '0;
			end
		end else begin
			if (err_q) begin
				wr_en  = (cnt_q != 3'd0);
				wr_idx = TAP_W'(cnt_q);
				cnt_n  = cnt_inc;
				if (cnt_inc >= 3'd3) begin
					cnt_n      = '0;
					hdr_n      = HDR_IDLE;
					err_n      = 1'b0;
					emit       = 1'b1;
					emit_kind  = KIND_ERROR;
					emit_ekind = (bb2 <= {5'd0, ECODE_MAX}) ? bb2[2:0] : ECODE_OTHER;
				end
			end else if (byte_s1 == BYTE_SYNC && hdr_q == HDR_IDLE) begin
				hdr_n = HDR_SYNC;
			end else if (byte_s1 == BYTE_ID && hdr_q == HDR_SYNC) begin
				hdr_n = HDR_ID;
			end else if (byte_s1 == BYTE_READ && hdr_q == HDR_ID) begin
				hdr_n = HDR_READ;
			end else if (byte_s1 == BYTE_ERR && hdr_q == HDR_ID) begin
				hdr_n = HDR_IDLE;
				err_n = 1'b1;
				cnt_n = '0;
			end else if (hdr_q == HDR_READ) begin
				wr_en  = (cnt_q != 3'd0);
				wr_idx = TAP_W'(cnt_q);
				cnt_n  = cnt_inc;
				if (cnt_inc >= 3'd7) begin
					cnt_n = '0;
					hdr_n = HDR_IDLE;
					if (bb2 != BYTE_SKIP) begin
						emit   = 1'b1;
						sys_n  = $signed({3'd0, bb3});
						dia_n  = $signed({3'd0, bb5});
						rate_n = $signed({3'd0, bb6});
					end
				end
			end else begin
				cnt_n = '0;
				hdr_n = HDR_IDLE;
			end
		end
	end

	// A byte with a result waits for room in the result register
	assign fire_s1  = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	// Hold the format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_BINARY;
		end else if (cfg_wr_en) begin
			fmt_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// Parser state and held readings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hdr_q  <= HDR_IDLE;
			err_q  <= 1'b0;
			cnt_q  <= '0;
			sys_q  <= '0;
			dia_q  <= '0;
			rate_q <= '0;
		end else if (fire_s1) begin
			pos_q  <= pos_n;
			hdr_q  <= hdr_n;
			err_q  <= err_n;
			cnt_q  <= cnt_n;
			sys_q  <= sys_n;
			dia_q  <= dia_n;
			rate_q <= rate_n;
		end
	end

	// Frame store: only the entries up to the highest index that a decode reads are kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST_TAP; k++) begin
				store_q[k] <= '0;
			end
		end else if (fire_s1 && wr_en) begin
			for (int k = 1; k <= LAST_TAP; k++) begin
				if (wr_idx == TAP_W'(k)) begin
					store_q[k] <= byte_s1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			kind_q  <= emit_kind;
			ekind_q <= emit_ekind;
		end
	end

	// Held readings only change when a result is loaded, so they stay put while it waits
	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign error_kind  = ekind_q;
	assign systolic    = sys_q;
	assign diastolic   = dia_q;
	assign heart_rate  = rate_q;

endmodule

`default_nettype wire

// ===== dv/tb_bp_sensor_frame_parser.sv =====
// Self-checking testbench for bp_sensor_frame_parser: ASCII and binary frames, format switching.
// Depends on bpsfp_pkg and the parser RTL; a built-in predictor supplies the expected results.
`timescale 1ns / 100ps

module tb_bp_sensor_frame_parser;
	import bpsfp_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int ITEM_TARGET    = 1100;

	// Payload characters
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_8     = 8'h38;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_X     = 8'h78;

	localparam logic [2:0] ECODE_NONE = 3'd0;

	typedef enum logic [1:0] {OP_BYTE, OP_CFG, OP_PAUSE} stim_op_e;
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BEAT, RX_SLUMP} rx_mode_e;

	typedef struct {
		stim_op_e   op;
		logic [7:0] value;
	} stim_t;

	typedef struct {
		logic [1:0]         kind;
		logic signed [10:0] sys;
		logic signed [10:0] dia;
		logic signed [10:0] rate;
		logic [2:0]         ekind;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	logic [1:0] result_kind;
	logic signed [10:0] systolic;
	logic signed [10:0] diastolic;
	logic signed [10:0] heart_rate;
	logic [2:0] error_kind;

	bp_sensor_frame_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.systolic    (systolic),
		.diastolic   (diastolic),
		.heart_rate  (heart_rate),
		.error_kind  (error_kind)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	stim_t         stim_queue [$];
	frame_result_t result_queue [$];
	logic [7:0]    seq [$];

	int n_items;
	int n_taken;
	int n_cfg_writes;
	int n_errors;
	int n_readings;
	int n_fetches;
	int n_err_reports;

	// Parser image: format, capture position, shared store, binary header and held readings
	logic               fmt_model = FMT_BINARY;
	int                 cap_pos = 0;
	logic [7:0]         store_img [STORE_DEPTH_DEF];
	logic [1:0]         hdr_state = HDR_IDLE;
	bit                 err_collect = 1'b0;
	logic [2:0]         bin_idx = 3'd0;
	logic signed [10:0] hold_sys = '0;
	logic signed [10:0] hold_dia = '0;
	logic signed [10:0] hold_rate = '0;

	initial begin
		foreach (store_img[i]) store_img[i] = 8'h00;
	end

	task automatic push_result(input logic [1:0] kind, input logic [2:0] ekind);
		frame_result_t r;
		r.kind  = kind;
		r.sys   = hold_sys;
		r.dia   = hold_dia;
		r.rate  = hold_rate;
		r.ekind = ekind;
		result_queue.push_back(r);
	endtask

	// Three-character decimal field: blanks, optional sign, digits up to the first non-digit
	function automatic logic signed [10:0] dec3(input int at);
		int i;
		bit neg;
		int v;
		i = 0;
		neg = 1'b0;
		v = 0;
		while (i < 3 && (store_img[at + i] == CH_SPACE ||
				(store_img[at + i] >= CH_TAB && store_img[at + i] <= BYTE_CR)))
			i++;
		if (i < 3 && (store_img[at + i] == CH_PLUS || store_img[at + i] == CH_MINUS)) begin
			neg = store_img[at + i] == CH_MINUS;
			i++;
		end
		while (i < 3 && store_img[at + i] >= CH_0 && store_img[at + i] <= CH_9) begin
			v = v * 10 + (int'(store_img[at + i]) - int'(CH_0));
			i++;
		end
		return 11'(neg ? -v : v);
	endfunction

	// Advance the parser image by one accepted byte and queue any result it causes
	task automatic parse_byte(input logic [7:0] b);
		int len;
		logic [7:0] code;
		if (fmt_model == FMT_ASCII) begin
			if (b == BYTE_CR) cap_pos = 0;
			if (cap_pos == 0 && b == BYTE_STX) begin
				store_img[0] = BYTE_STX;
				cap_pos = 1;
			end else if (cap_pos > 0 && cap_pos < STORE_DEPTH_DEF) begin
				store_img[cap_pos] = b;
				cap_pos++;
				if (b == BYTE_ETX) begin
					len = cap_pos - 2;
					cap_pos = 0;
					if (len == 3 && store_img[1] == CH_9 && store_img[2] == CH_9 &&
							store_img[3] == CH_9) begin
						push_result(KIND_FETCH, ECODE_NONE);
					end else if (len >= 24 && store_img[1] == CH_S && store_img[2] == CH_1 &&
							store_img[11] == CH_M && store_img[12] == CH_0 &&
							store_img[13] == CH_3) begin
						hold_sys  = dec3(16);
						hold_dia  = dec3(19);
						hold_rate = dec3(22);
						push_result(KIND_READING, ECODE_NONE);
					end
				end
			end else begin
				cap_pos = 0;
			end
		end else if (err_collect) begin
			store_img[bin_idx] = b;
			bin_idx++;
			if (bin_idx >= 3) begin
				code = store_img[2];
				bin_idx = 0;
				hdr_state = HDR_IDLE;
				err_collect = 1'b0;
				push_result(KIND_ERROR, (code <= ECODE_MAX) ? code[2:0] : ECODE_OTHER);
			end
		end else if (b == BYTE_SYNC && hdr_state == HDR_IDLE) begin
			hdr_state = HDR_SYNC;
		end else if (b == BYTE_ID && hdr_state == HDR_SYNC) begin
			hdr_state = HDR_ID;
		end else if (b == BYTE_READ && hdr_state == HDR_ID) begin
			hdr_state = HDR_READ;
		end else if (b == BYTE_ERR && hdr_state == HDR_ID) begin
			hdr_state = HDR_IDLE;
			err_collect = 1'b1;
			bin_idx = 0;
		end else if (hdr_state == HDR_READ) begin
			store_img[bin_idx] = b;
			bin_idx++;
			if (bin_idx >= 7) begin
				bin_idx = 0;
				hdr_state = HDR_IDLE;
				if (store_img[2] != BYTE_SKIP) begin
					hold_sys  = {3'b000, store_img[3]};
					hold_dia  = {3'b000, store_img[5]};
					hold_rate = {3'b000, store_img[6]};
					push_result(KIND_READING, ECODE_NONE);
				end
			end
		end else begin
			bin_idx = 0;
			hdr_state = HDR_IDLE;
		end
	endtask

	// Sender: bursts and gaps on bytes; format writes and pauses only once the parser is idle
	int gap_left;
	int burst_left;
	int settle_cnt;
	bit took;
	bit nxt_valid;
	bit wr_now;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			cfg_wr_en <= 1'b0;
			cfg_wr_data <= FMT_BINARY;
			gap_left = 0;
			burst_left = 1;
			settle_cnt = 0;
		end else begin
			took = in_valid && in_ready;
			if (took) begin
				parse_byte(rx_byte);
				n_taken++;
			end
			wr_now = 1'b0;
			nxt_valid = in_valid && !took;
			if (!nxt_valid && stim_queue.size() != 0) begin
				if (stim_queue[0].op == OP_BYTE) begin
					if (gap_left != 0) begin
						gap_left--;
					end else begin
						nxt_valid = 1'b1;
						rx_byte <= stim_queue[0].value;
						void'(stim_queue.pop_front());
						if (burst_left <= 1) begin
							burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
							gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
						end else begin
							burst_left--;
						end
					end
				end else if (!in_valid && result_queue.size() == 0) begin
					if (settle_cnt < SETTLE_CYCLES) begin
						settle_cnt++;
					end else begin
						settle_cnt = 0;
						if (stim_queue[0].op == OP_CFG) begin
							wr_now = 1'b1;
							cfg_wr_data <= stim_queue[0].value[0];
							fmt_model = stim_queue[0].value[0];
							n_cfg_writes++;
						end
						void'(stim_queue.pop_front());
					end
				end else begin
					settle_cnt = 0;
				end
			end
			in_valid <= nxt_valid;
			cfg_wr_en <= wr_now;
		end
	end

	// Receiver: the stall pattern is redrawn at random among four modes
	rx_mode_e rx_mode;
	int rx_cycle;
	int stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode = RX_OPEN;
			rx_cycle = 0;
			stall_left = 0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 300 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
			case (rx_mode)
				RX_OPEN: begin
					out_ready <= 1'b1;
				end
				RX_COIN: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				RX_BEAT: begin
					out_ready <= (rx_cycle % 4) != 0;
				end
				default: begin
					if (stall_left != 0) begin
						stall_left--;
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
						if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 20);
					end
				end
			endcase
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			n_errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Compare each accepted result with the oldest expectation
	frame_result_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (result_queue.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result: expected none, actual kind %0d sys %0d",
					$time, result_kind, systolic);
			end else begin
				want = result_queue.pop_front();
				check_field("result_kind", want.kind, result_kind);
				check_field("systolic", want.sys, systolic);
				check_field("diastolic", want.dia, diastolic);
				check_field("heart_rate", want.rate, heart_rate);
				check_field("error_kind", want.ekind, error_kind);
				case (want.kind)
					KIND_READING: n_readings++;
					KIND_FETCH:   n_fetches++;
					default:      n_err_reports++;
				endcase
			end
		end
	end

	// Watchdog on cycles without any handshake or write
	int quiet_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired with %0d results outstanding",
					$time, result_queue.size());
				$display("tb_bp_sensor_frame_parser: done, errors");
				$finish;
			end
		end
	end

	// Stimulus builders
	task automatic put_byte(input logic [7:0] b);
		stim_t s;
		s.op = OP_BYTE;
		s.value = b;
		stim_queue.push_back(s);
		n_items++;
	endtask

	task automatic put_seq();
		foreach (seq[i]) put_byte(seq[i]);
	endtask

	task automatic put_cfg(input logic f);
		stim_t s;
		s.op = OP_CFG;
		s.value = {7'd0, f};
		stim_queue.push_back(s);
	endtask

	function automatic logic [7:0] wide_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Payload byte that neither ends nor aborts an ASCII frame
	function automatic logic [7:0] frame_filler();
		logic [7:0] b;
		do b = 8'($urandom); while (b == BYTE_ETX || b == BYTE_CR);
		return b;
	endfunction

	function automatic logic [7:0] field_char();
		case ($urandom_range(0, 11))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			3: return CH_PLUS;
			4: return CH_MINUS;
			5: return CH_X;
			6: return 8'h00;
			default: return CH_0 + 8'($urandom_range(0, 9));
		endcase
	endfunction

	// Reading frame; extra < 0 cuts the payload one short, and markers are spoilt at times
	task automatic asc_reading(input int extra);
		int spoil;
		seq = '{BYTE_STX, CH_S, CH_1};
		repeat (8) seq.push_back(frame_filler());
		seq.push_back(CH_M);
		seq.push_back(CH_0);
		seq.push_back(CH_3);
		repeat (2) seq.push_back(frame_filler());
		repeat (9) seq.push_back(field_char());
		if (extra < 0)
			void'(seq.pop_back());
		else
			repeat (extra) seq.push_back(frame_filler());
		spoil = $urandom_range(0, 11);
		if (spoil < 5) seq[spoil < 2 ? spoil + 1 : spoil + 9] ^= 8'h20;
		seq.push_back(BYTE_ETX);
		put_seq();
	endtask

	task automatic asc_fetch();
		int variant;
		variant = $urandom_range(0, 5);
		seq = '{BYTE_STX};
		repeat ((variant == 3) ? 2 : (variant == 4) ? 4 : 3) seq.push_back(CH_9);
		if (variant == 5) seq[2] = CH_8;
		seq.push_back(BYTE_ETX);
		put_seq();
	endtask

	task automatic asc_abort();
		seq = '{BYTE_STX};
		repeat ($urandom_range(0, 20)) seq.push_back(frame_filler());
		seq.push_back(BYTE_CR);
		put_seq();
	endtask

	// Bytes outside a frame are ignored
	task automatic asc_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 4)) begin
			do b = 8'($urandom); while (b == BYTE_STX);
			put_byte(b);
		end
	endtask

	// Full-store frames: a reading that ends in the last slot, or one byte too many
	task automatic asc_long(input bit overflow);
		seq = '{BYTE_STX};
		repeat (overflow ? 255 : 254) seq.push_back(frame_filler());
		if (!overflow) begin
			seq[1] = CH_S;
			seq[2] = CH_1;
			seq[11] = CH_M;
			seq[12] = CH_0;
			seq[13] = CH_3;
			for (int i = 16; i < 25; i++) seq[i] = field_char();
		end
		seq.push_back(BYTE_ETX);
		put_seq();
	endtask

	task automatic bin_reading(input bit skip);
		seq = '{BYTE_SYNC, BYTE_ID, BYTE_READ};
		repeat (7) seq.push_back(wide_byte());
		if (skip) seq[5] = BYTE_SKIP;
		put_seq();
	endtask

	task automatic bin_error(input logic [7:0] code);
		seq = '{BYTE_SYNC, BYTE_ID, BYTE_ERR, wide_byte(), wide_byte(), code};
		put_seq();
	endtask

	task automatic bin_broken();
		logic [7:0] b;
		case ($urandom_range(0, 3))
			0: begin
				do b = 8'($urandom); while (b == BYTE_ID);
				seq = '{BYTE_SYNC, b};
			end
			1: begin
				do b = 8'($urandom); while (b == BYTE_READ || b == BYTE_ERR);
				seq = '{BYTE_SYNC, BYTE_ID, b};
			end
			2: seq = '{BYTE_SYNC, BYTE_SYNC, BYTE_ID, BYTE_READ};
			default: seq = '{BYTE_ID, BYTE_READ, BYTE_ERR};
		endcase
		put_seq();
	endtask

	task automatic bin_noise();
		repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
	endtask

	// Stimulus, reset and end of run
	logic cur_fmt;
	int phase;
	bit long_done;
	stim_t pause_item;

	initial begin
		n_items = 0;
		n_taken = 0;
		n_cfg_writes = 0;
		n_errors = 0;
		n_readings = 0;
		n_fetches = 0;
		n_err_reports = 0;

		// Directed: binary extremes, error code out of range, fetch, CR abort
		put_cfg(FMT_BINARY);
		seq = '{BYTE_SYNC, BYTE_ID, BYTE_READ,
			8'h00, 8'hFF, 8'h02, 8'hFF, 8'h80, 8'h00, 8'hFF};
		put_seq();
		seq = '{BYTE_SYNC, BYTE_ID, BYTE_ERR, 8'h00, 8'hFF, 8'hFF};
		put_seq();
		put_cfg(FMT_ASCII);
		seq = '{BYTE_STX, CH_9, CH_9, CH_9, BYTE_ETX,
			BYTE_STX, CH_9, BYTE_CR, CH_9, CH_9, BYTE_ETX};
		put_seq();

		// Random phases, each under one format setting
		cur_fmt = FMT_ASCII;
		phase = 0;
		long_done = 1'b0;
		while (n_items < ITEM_TARGET) begin
			if (phase > 0 && $urandom_range(0, 3) != 0) cur_fmt = ~cur_fmt;
			put_cfg(cur_fmt);
			if (cur_fmt == FMT_ASCII && !long_done) begin
				asc_long(1'b0);
				asc_long(1'b1);
				asc_fetch();
				long_done = 1'b1;
			end
			for (int s = 0; s < $urandom_range(4, 12); s++) begin
				if (phase == 6 && s == 2) begin
					pause_item.op = OP_PAUSE;
					pause_item.value = 8'h00;
					stim_queue.push_back(pause_item);
				end
				if (cur_fmt == FMT_ASCII) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: asc_reading(int'($urandom_range(0, 4)) - 1);
						5, 6: asc_fetch();
						7: asc_abort();
						default: asc_noise();
					endcase
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: bin_reading($urandom_range(0, 4) == 0);
						5, 6: bin_error(($urandom_range(0, 1) == 0) ?
							8'($urandom_range(0, 7)) : wide_byte());
						7: bin_broken();
						8: bin_error(8'($urandom_range(0, 4)));
						default: bin_noise();
					endcase
				end
			end
			// Leave a frame half-captured across the next format change now and then
			if ($urandom_range(0, 2) == 0) begin
				if (cur_fmt == FMT_ASCII) begin
					seq = '{BYTE_STX};
					repeat ($urandom_range(0, 12)) seq.push_back(frame_filler());
				end else begin
					seq = '{BYTE_SYNC, BYTE_ID, ($urandom_range(0, 1) == 0) ? BYTE_READ : BYTE_ERR};
					repeat ($urandom_range(0, 2)) seq.push_back(wide_byte());
				end
				put_seq();
			end
			phase++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stim_queue.size() != 0 || in_valid || result_queue.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d bytes, %0d format writes over %0d phases",
			n_taken, n_cfg_writes, phase);
		$display("checked %0d readings, %0d fetch requests, %0d error reports",
			n_readings, n_fetches, n_err_reports);
		if (n_errors == 0)
			$display("tb_bp_sensor_frame_parser: done, clean");
		else
			$display("tb_bp_sensor_frame_parser: done, errors");
		$finish;
	end

endmodule
